FILE: sv/rmv_pkg.sv
// Package: types and constants for the running mean/variance unit.
package rmv_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_MUL1,
		ST_MUL2,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start_mean;
		logic start_var;
		logic mul1;
		logic mul2;
		logic mul3;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic clear;
		logic saturated;
		logic first;
	} sts_t;
endpackage

FILE: sv/rmv_div.sv
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
module rmv_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic         done
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = done_q;
endmodule

FILE: sv/rmv_ctrl.sv
// Controller: sequences the divides, multiplies and the state update of one request.
module rmv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  rmv_pkg::sts_t sts,
	output rmv_pkg::cmd_t cmd
);
	import rmv_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: begin
				if (sts.clear || sts.saturated) begin
					cmd.update = 1'b1;
					state_d    = ST_OUT;
				end else begin
					cmd.start_mean = 1'b1;
					state_d        = ST_DIV_VAR;
				end
			end
			ST_DIV_VAR: begin
				if (sts.div_done) begin
					if (sts.first) begin
						cmd.update = 1'b1;
						state_d    = ST_OUT;
					end else begin
						cmd.start_var = 1'b1;
						cmd.mul1      = 1'b1;
						state_d       = ST_MUL1;
					end
				end
			end
			ST_MUL1: begin
				if (sts.div_done) begin
					cmd.mul2 = 1'b1;
					state_d  = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cmd.mul3 = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_out_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> state_q == ST_OUT) else $error("update not followed by output");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_stall) |=> state_q == ST_OUT) else $error("output lost");
`endif
endmodule

FILE: sv/rmv_dp.sv
// Datapath: statistics registers, divider, multiplier and saturation logic.
module rmv_dp #(
	parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS = rmv_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  rmv_pkg::cmd_t                            cmd,
	output rmv_pkg::sts_t                            sts,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     clear,
	output logic [COUNT_BITS-1:0]                    sample_count,
	output logic signed [SAMPLE_BITS-1:0]            minimum,
	output logic signed [SAMPLE_BITS-1:0]            maximum,
	output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]  mean_q16,
	output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]       variance_q16,
	output logic                                     dropped
);
	import rmv_pkg::*;

	localparam int MB = SAMPLE_BITS + FRAC_BITS;
	localparam int VB = 2 * SAMPLE_BITS + FRAC_BITS;
	localparam int DW = (VB > MB + 1) ? VB : MB + 1;
	localparam int PB = COUNT_BITS + 1 + MB;

	logic [COUNT_BITS-1:0]      count_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q, x_q;
	logic signed [MB-1:0]       mean_q;
	logic [VB-1:0]              var_q;
	logic                       clear_q, drop_q;
	logic signed [MB:0]         diff_q;
	logic [MB-1:0]              ad_q;
	logic [PB-1:0]              p_q;
	logic [PB+MB-1:0]           sq_q;
	logic signed [MB:0]         stepv_q;
	logic                       div_start, div_done;
	logic [DW-1:0]              div_a, div_b, div_qo;
	logic [MB:0]                absdiff;
	logic signed [MB:0]         stepv;
	logic [PB+MB-FRAC_BITS-1:0] sqs;
	logic [VB:0]                term, total;
	logic [VB-1:0]              sq_sat;
	logic [PB-1:0]              p_prod;
	logic [2*MB-1:0]            prod_lo;
	logic [PB-1:0]              prod_hi;

	assign absdiff = diff_q[MB] ? -diff_q : diff_q;
	assign div_start = cmd.start_mean || cmd.start_var;
	assign div_a = cmd.start_mean ? DW'(absdiff) : DW'(var_q);
	assign div_b = cmd.start_mean ? DW'({1'b0, count_q} + 1'b1) : DW'(count_q);

	rmv_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .quotient(div_qo), .done(div_done)
	);

	assign stepv = diff_q[MB] ? -$signed(div_qo[MB:0]) : $signed(div_qo[MB:0]);
	assign sqs = sq_q[PB+MB-1:FRAC_BITS];
	assign sq_sat = (|(sqs >> VB)) ? '1 : sqs[VB-1:0];
	assign term = {1'b0, var_q} - {1'b0, div_qo[VB-1:0]};
	assign total = term + {1'b0, sq_sat};

	// (n+1)*|step|, then that product times |step| in two partial products
	assign p_prod = ({1'b0, count_q} + 1'b1) * div_qo[MB-1:0];
	assign prod_lo = p_q[MB-1:0] * ad_q;
	assign prod_hi = p_q[PB-1:MB] * ad_q;

	assign sts.div_done = div_done;
	assign sts.clear = clear_q;
	assign sts.saturated = &count_q;
	assign sts.first = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			mean_q  <= '0;
			var_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.update) begin
			drop_q <= 1'b0;
			if (clear_q) begin
				count_q <= '0;
				min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
				max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				mean_q  <= '0;
				var_q   <= '0;
			end else if (&count_q) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				if (x_q < min_q) min_q <= x_q;
				if (x_q > max_q) max_q <= x_q;
				if (count_q == '0) begin
					mean_q <= MB'(mean_q + stepv);
				end else begin
					mean_q <= MB'(mean_q + stepv_q);
					var_q  <= total[VB] ? '1 : total[VB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= sample;
			clear_q <= clear;
			diff_q  <= {{1{sample[SAMPLE_BITS-1]}}, sample, {FRAC_BITS{1'b0}}}
				- {mean_q[MB-1], mean_q};
		end
		if (cmd.mul1) begin
			stepv_q <= stepv;
			ad_q    <= MB'(div_qo);
			p_q     <= p_prod;
		end
		if (cmd.mul2) sq_q <= {{(PB-MB){1'b0}}, prod_lo};
		if (cmd.mul3) sq_q <= sq_q + {prod_hi, {MB{1'b0}}};
	end

	assign sample_count = count_q;
	assign minimum = min_q;
	assign maximum = max_q;
	assign mean_q16 = mean_q;
	assign variance_q16 = var_q;
	assign dropped = drop_q;

`ifndef SYNTH
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> min_q <= max_q) else $error("min above max");
	a_empty_var: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> var_q == '0) else $error("variance without samples");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !clear_q) |=> (count_q == $past(count_q) + 1'b1) || (&count_q))
		else $error("count step");
`endif
endmodule

FILE: sv/running_mean_variance_minmax_unit.sv
// Running mean, variance, min and max of a signed sample stream.
// Input channel: in_valid/in_stall carries sample and clear; a request is taken
// when in_valid is high and in_stall low. clear=1 restarts the statistics.
// Output channel: out_valid/out_stall carries the updated statistics, one
// result per request; a result holds while out_stall is high.
// One request at a time. A clear or saturated request skips the divider; a
// first sample runs the mean divide only; later samples run the mean divide,
// then the variance divide and the multiplies, on the single one-bit-per-cycle
// divider used for the mean and variance, of width
// DW = max(2*SAMPLE_BITS+FRAC_BITS, SAMPLE_BITS+FRAC_BITS+1) (48 by default).
// in_stall stays high until the result is taken, so the next request is taken
// in the cycle after that at the earliest; a stalled result holds off the input.
// Reset clears count, mean and variance, min to the largest, max to the most
// negative sample value.
module running_mean_variance_minmax_unit #(
	parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS = rmv_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	input  logic                                    clear,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [COUNT_BITS-1:0]                   sample_count,
	output logic signed [SAMPLE_BITS-1:0]           minimum,
	output logic signed [SAMPLE_BITS-1:0]           maximum,
	output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_q16,
	output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]      variance_q16,
	output logic                                    dropped
);
	import rmv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rmv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	rmv_dp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sample(sample), .clear(clear),
		.sample_count(sample_count), .minimum(minimum), .maximum(maximum),
		.mean_q16(mean_q16), .variance_q16(variance_q16), .dropped(dropped)
	);
endmodule
